// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted during reset.
`define STR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stepper ramp assertion failed");

// Next-cycle implication, muted during reset.
`define STR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stepper ramp assertion failed");

`endif

// ----- rtl/str_pkg.sv -----
// Package for the stepper trapezoid ramp: widths, codes, stage and FSM types.
// No dependencies; used by the interfaces, the top level and the checker.
package str_pkg;

  localparam int POS_W      = 32;
  localparam int RATE_W     = 16;
  localparam int RELOAD_W   = 16;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // timer base 2000000 fits in 21 bits; one quotient bit per cycle
  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] TIMER_BASE = 21'd2000000;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_STEP  = 2'd1,
    ACT_START = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STG_STOP   = 2'd0,
    STG_ACCEL  = 2'd1,
    STG_CRUISE = 2'd2,
    STG_DECEL  = 2'd3
  } stage_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_INC  = 3'd0,
    REG_CRUISE     = 3'd1,
    REG_DECEL_DEC  = 3'd2,
    REG_ACCEL_END  = 3'd3,
    REG_CRUISE_END = 3'd4,
    REG_MOVE_END   = 3'd5,
    REG_SHORT_MOVE = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_PUSH = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic [RELOAD_W-1:0] reload_period;
    logic                period_valid;
    stage_t              stage;
    logic [POS_W-1:0]    position;
    logic                busy_res;
    logic                move_done;
  } result_t;

endpackage

// ----- rtl/str_if.sv -----
// Valid/ready channel interfaces: command beats in, result beats out.
// Depends on str_pkg for field widths.
interface str_cmd_if;
  import str_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic       direction;
  modport source (output valid, action, direction, input ready);
  modport sink   (input valid, action, direction, output ready);
endinterface

interface str_res_if;
  import str_pkg::*;
  logic                       valid;
  logic                       ready;
  logic        [RELOAD_W-1:0] reload_period;
  logic                       period_valid;
  logic        [1:0]          stage;
  logic signed [POS_W-1:0]    position;
  logic                       busy_res;
  logic                       move_done;
  modport source (output valid, reload_period, period_valid, stage, position, busy_res,
                  move_done, input ready);
  modport sink   (input valid, reload_period, period_valid, stage, position, busy_res,
                  move_done, output ready);
endinterface

// ----- rtl/stepper_trapezoid_ramp.sv -----
// One-axis trapezoidal/triangular stepper profile with bit-serial reload divider.
// Depends on str_pkg and the channel interfaces in str_if.sv.
//
//   channel  dir  handshake     beat contents
//   cmd      in   valid/ready   action, direction
//   res      out  valid/ready   reload_period, period_valid, stage, position,
//                               busy_res, move_done
//   cfg      in   cfg_we        cfg_index, cfg_data (no read-back)
//
// Steps: a ramp tick during a move with nonzero rate goes from accept through
//   21 restoring-division steps to the load of the result register; the
//   one-bit-per-cycle divider computes 2000000/rate. Every other beat goes
//   from accept straight to the load. The load waits while res is stalled.
// One beat is in work at a time; cmd.ready is high only while idle.
// A finished result waits in the output register while the next beat is
//   taken; a stalled res side holds the next result in the pending register.
// Reset (rst, synchronous) clears FSM, config, position, stage, rate, busy, out valid.
module stepper_trapezoid_ramp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [str_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [str_pkg::CFG_DATA_W-1:0]  cfg_data,
  str_cmd_if.sink                         cmd,
  str_res_if.source                       res
);
  import str_pkg::*;

  // configuration registers
  logic [RATE_W-1:0] accel_increment;
  logic [RATE_W-1:0] cruise_rate;
  logic [RATE_W-1:0] decel_decrement;
  logic [POS_W-1:0]  accel_end_position;
  logic [POS_W-1:0]  cruise_end_position;
  logic [POS_W-1:0]  move_end_position;
  logic              short_move;

  // axis state
  logic [POS_W-1:0]  step_count;
  stage_t            motion_stage;
  logic [RATE_W-1:0] step_rate;
  logic              busy;

  // FSM
  ctrl_state_t state, state_next;
  logic        cmd_fire;
  logic        res_load;

  // beat evaluation
  logic [RATE_W:0]   rate_sum;
  logic [POS_W-1:0]  count_step;
  logic [POS_W-1:0]  count_next;
  stage_t            stage_next;
  logic [RATE_W-1:0] rate_next;
  logic              busy_next;
  logic              item_done;
  logic              item_period;
  logic              start_div;

  // pending result and divider
  result_t              pend;
  result_t              pend_out;
  logic                 pend_div;
  logic [RATE_W-1:0]    rem;
  logic [DIV_W-1:0]     dvd;     // dividend in, quotient shifted in from the bottom
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_last;
  logic [RATE_W:0]      trial;
  logic                 trial_ge;
  logic [RATE_W:0]      trial_diff;
  logic [DIV_W-1:0]     quot_m1;
  logic [RELOAD_W-1:0]  reload_div;

  // output register
  logic    out_valid;
  result_t out_res;

  assign cmd_fire = cmd.valid && cmd.ready;

  // ---------------------------------------------------------------------------
  // Beat evaluation: new position, stage, rate and flags for the beat on cmd.
  // ---------------------------------------------------------------------------
  always_comb begin
    rate_sum    = {1'b0, step_rate} + {1'b0, accel_increment};
    count_step  = cmd.direction ? step_count + POS_W'(1) : step_count - POS_W'(1);
    count_next  = step_count;
    stage_next  = motion_stage;
    rate_next   = step_rate;
    busy_next   = busy;
    item_done   = 1'b0;
    item_period = 1'b0;
    unique case (action_t'(cmd.action))
      ACT_TICK: begin
        unique case (motion_stage)
          STG_ACCEL:  rate_next = rate_sum[RATE_W] ? '1 : rate_sum[RATE_W-1:0];
          STG_CRUISE: rate_next = cruise_rate;
          STG_DECEL:  rate_next = (step_rate > decel_decrement) ?
                                  step_rate - decel_decrement : '0;
          STG_STOP:   rate_next = step_rate;
        endcase
        item_period = busy;
      end
      ACT_STEP: begin
        count_next = count_step;
        // accel end wins over cruise end, which wins over move end
        if (count_step == accel_end_position) begin
          stage_next = short_move ? STG_DECEL : STG_CRUISE;
        end else if (count_step == cruise_end_position && !short_move) begin
          stage_next = STG_DECEL;
        end else if (motion_stage == STG_DECEL && count_step == move_end_position) begin
          stage_next = STG_STOP;
          busy_next  = 1'b0;
          rate_next  = '0;
          item_done  = 1'b1;
        end
      end
      ACT_START: begin
        busy_next  = 1'b1;
        stage_next = STG_ACCEL;
        rate_next  = '0;
      end
      ACT_NOP: begin
        busy_next = busy;
      end
    endcase
    // zero rate reloads all ones without dividing
    start_div = item_period && (rate_next != '0);
  end

  // ---------------------------------------------------------------------------
  // Restoring divider step: one quotient bit per cycle.
  // ---------------------------------------------------------------------------
  always_comb begin
    trial      = {rem, dvd[DIV_W-1]};
    trial_ge   = trial >= {1'b0, step_rate};
    trial_diff = trial - {1'b0, step_rate};
    div_last   = div_cnt == DIV_CNT_W'(DIV_W - 1);
    // reload = quotient - 1, clipped to 16 bits (quotient is at least 30 here)
    quot_m1    = dvd - DIV_W'(1);
    reload_div = (|quot_m1[DIV_W-1:RELOAD_W]) ? '1 : quot_m1[RELOAD_W-1:0];
    // result as it goes to the output register
    pend_out   = pend;
    if (pend_div) begin
      pend_out.reload_period = reload_div;
    end
  end

  // ---------------------------------------------------------------------------
  // Control FSM
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.ready  = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.ready = 1'b1;
        if (cmd.valid) begin
          state_next = start_div ? ST_DIV : ST_PUSH;
        end
      end
      ST_DIV: begin
        if (div_last) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!out_valid || res.ready) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control state: config, axis state, output valid
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_increment     <= '0;
      cruise_rate         <= '0;
      decel_decrement     <= '0;
      accel_end_position  <= '0;
      cruise_end_position <= '0;
      move_end_position   <= '0;
      short_move          <= 1'b0;
      step_count          <= '0;
      motion_stage        <= STG_STOP;
      step_rate           <= '0;
      busy                <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_ACCEL_INC:  accel_increment     <= cfg_data[RATE_W-1:0];
          REG_CRUISE:     cruise_rate         <= cfg_data[RATE_W-1:0];
          REG_DECEL_DEC:  decel_decrement     <= cfg_data[RATE_W-1:0];
          REG_ACCEL_END:  accel_end_position  <= cfg_data[POS_W-1:0];
          REG_CRUISE_END: cruise_end_position <= cfg_data[POS_W-1:0];
          REG_MOVE_END:   move_end_position   <= cfg_data[POS_W-1:0];
          REG_SHORT_MOVE: short_move          <= cfg_data[0];
          default:        ;
        endcase
      end
      if (cmd_fire) begin
        step_count   <= count_next;
        motion_stage <= stage_next;
        step_rate    <= rate_next;
        busy         <= busy_next;
      end
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload: pending result, divider shift registers, output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      pend.reload_period <= item_period ? '1 : '0;
      pend.period_valid  <= item_period;
      pend.stage         <= stage_next;
      pend.position      <= count_next;
      pend.busy_res      <= busy_next;
      pend.move_done     <= item_done;
      pend_div           <= start_div;
      rem                <= '0;
      dvd                <= TIMER_BASE;
      div_cnt            <= '0;
    end else if (state == ST_DIV) begin
      rem     <= trial_ge ? trial_diff[RATE_W-1:0] : trial[RATE_W-1:0];
      dvd     <= {dvd[DIV_W-2:0], trial_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (res_load) begin
      out_res <= pend_out;
    end
  end

  assign res.valid         = out_valid;
  assign res.reload_period = out_res.reload_period;
  assign res.period_valid  = out_res.period_valid;
  assign res.stage         = out_res.stage;
  assign res.position      = signed'(out_res.position);
  assign res.busy_res      = out_res.busy_res;
  assign res.move_done     = out_res.move_done;

endmodule

// ----- rtl/str_checker.sv -----
// Port-level checker for stepper_trapezoid_ramp, attached by bind below.
// Depends on str_pkg and assert_macros.svh.
`include "assert_macros.svh"

module str_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         res_valid,
  input logic                         res_ready,
  input logic [str_pkg::RELOAD_W-1:0] reload_period,
  input logic                         period_valid,
  input logic [1:0]                   stage,
  input logic                         busy_res,
  input logic                         move_done
);
  import str_pkg::*;

  // a reload only comes out during a move
  `STR_ASSERT_IMP(a_reload_in_move, clk, rst, res_valid && period_valid, busy_res && !move_done)
  // the step that ends a move leaves the axis stopped and free
  `STR_ASSERT_IMP(a_done_stops, clk, rst, res_valid && move_done, !busy_res && stage == STG_STOP)
  // no reload means a zero reload field
  `STR_ASSERT_IMP(a_no_reload_zero, clk, rst, res_valid && !period_valid, reload_period == '0)
  // stalled result beat holds its valid and reload field
  `STR_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(reload_period))

endmodule

bind stepper_trapezoid_ramp str_checker u_str_checker (
  .clk           (clk),
  .rst           (rst),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .reload_period (res.reload_period),
  .period_valid  (res.period_valid),
  .stage         (res.stage),
  .busy_res      (res.busy_res),
  .move_done     (res.move_done)
);
